FILE: design/lna_pkg.sv
// ----------------------------------------------------------------------------
// lna_pkg
// Shared types and constants of the leaky integrate-and-fire neuron array.
// ----------------------------------------------------------------------------
package lna_pkg;

  localparam int NEURONS_DEF = 1024;
  localparam int PADDR_W     = 5;

  // Register reset values.
  localparam logic [10:0]        RST_ACTIVE    = 11'd1000;
  localparam logic signed [15:0] RST_INIT_POT  = -16'sd17920;
  localparam logic signed [15:0] RST_THRESHOLD = -16'sd14080;
  localparam logic signed [15:0] RST_RESET_POT = -16'sd20480;
  localparam logic signed [15:0] RST_CURRENT   = 16'sd5120;
  localparam logic [15:0]        RST_LEAK      = 16'd62259;
  localparam logic signed [15:0] RST_TARGET    = 16'sd0;
  localparam logic [4:0]         RST_REFR      = 5'd20;

  typedef enum logic [1:0] {
    OP_STIM  = 2'd0,
    OP_TICK  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    REG_ACTIVE    = 3'd0,
    REG_INIT_POT  = 3'd1,
    REG_THRESHOLD = 3'd2,
    REG_RESET_POT = 3'd3,
    REG_CURRENT   = 3'd4,
    REG_LEAK      = 3'd5,
    REG_TARGET    = 3'd6,
    REG_REFR      = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [10:0]        active;
    logic signed [15:0] init_pot;
    logic signed [15:0] threshold;
    logic signed [15:0] reset_pot;
    logic signed [15:0] current;
    logic [15:0]        leak;
    logic signed [15:0] target;
    logic [4:0]         refr;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] pot;
    logic [4:0]         refr;
  } entry_t;

endpackage

FILE: design/lna_cfg_regs.sv
// ----------------------------------------------------------------------------
// lna_cfg_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module lna_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lna_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output lna_pkg::cfg_t               cfg
);

  lna_pkg::cfg_t    cfg_r;
  lna_pkg::reg_idx_t idx;
  logic             wr_en;

  assign idx    = lna_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active    <= lna_pkg::RST_ACTIVE;
      cfg_r.init_pot  <= lna_pkg::RST_INIT_POT;
      cfg_r.threshold <= lna_pkg::RST_THRESHOLD;
      cfg_r.reset_pot <= lna_pkg::RST_RESET_POT;
      cfg_r.current   <= lna_pkg::RST_CURRENT;
      cfg_r.leak      <= lna_pkg::RST_LEAK;
      cfg_r.target    <= lna_pkg::RST_TARGET;
      cfg_r.refr      <= lna_pkg::RST_REFR;
    end else if (wr_en) begin
      unique case (idx)
        lna_pkg::REG_ACTIVE:    cfg_r.active    <= pwdata[10:0];
        lna_pkg::REG_INIT_POT:  cfg_r.init_pot  <= pwdata[15:0];
        lna_pkg::REG_THRESHOLD: cfg_r.threshold <= pwdata[15:0];
        lna_pkg::REG_RESET_POT: cfg_r.reset_pot <= pwdata[15:0];
        lna_pkg::REG_CURRENT:   cfg_r.current   <= pwdata[15:0];
        lna_pkg::REG_LEAK:      cfg_r.leak      <= pwdata[15:0];
        lna_pkg::REG_TARGET:    cfg_r.target    <= pwdata[15:0];
        lna_pkg::REG_REFR:      cfg_r.refr      <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      lna_pkg::REG_ACTIVE:    prdata = {21'd0, cfg_r.active};
      lna_pkg::REG_INIT_POT:  prdata = {16'd0, cfg_r.init_pot};
      lna_pkg::REG_THRESHOLD: prdata = {16'd0, cfg_r.threshold};
      lna_pkg::REG_RESET_POT: prdata = {16'd0, cfg_r.reset_pot};
      lna_pkg::REG_CURRENT:   prdata = {16'd0, cfg_r.current};
      lna_pkg::REG_LEAK:      prdata = {16'd0, cfg_r.leak};
      lna_pkg::REG_TARGET:    prdata = {16'd0, cfg_r.target};
      lna_pkg::REG_REFR:      prdata = {27'd0, cfg_r.refr};
      default:                prdata = 32'd0;
    endcase
  end

endmodule

FILE: design/lna_neuron_ram.sv
// ----------------------------------------------------------------------------
// lna_neuron_ram
// Neuron state memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lna_neuron_ram #(
  parameter int DEPTH = lna_pkg::NEURONS_DEF,
  parameter int AW    = 10
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  lna_pkg::entry_t wdata,
  input  logic [AW-1:0]   raddr,
  output lna_pkg::entry_t rdata
);

  lna_pkg::entry_t mem [DEPTH];
  lna_pkg::entry_t rdata_r;

  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

FILE: design/lna_leak_unit.sv
// ----------------------------------------------------------------------------
// lna_leak_unit
// Shared neuron update pipeline: leak multiply, threshold compare and fire,
// refractory countdown, or a saturating stimulus add.
// ----------------------------------------------------------------------------
module lna_leak_unit #(
  parameter int AW = 10
) (
  input  logic            clk,
  input  logic            rst_n,
  input  lna_pkg::cfg_t   cfg,
  input  logic            in_valid,
  input  logic            in_add,
  input  logic [AW-1:0]   in_addr,
  input  lna_pkg::entry_t in_entry,
  output logic            pipe_busy,
  output logic            out_valid,
  output logic [AW-1:0]   out_addr,
  output lna_pkg::entry_t out_entry,
  output logic            out_fired
);

  function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
    logic signed [15:0] r;
    if (v > 19'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -19'sd32768) begin
      r = -16'sd32768;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // Stage B: deviation from the leak target, or the bypass value.
  logic                vb_r;
  logic [AW-1:0]       addr_b_r;
  logic signed [16:0]  diff_b_r;
  logic                alt_b_r;
  lna_pkg::entry_t     alt_ent_b_r;

  // Stage C: product and the bypass value.
  logic                vc_r;
  logic [AW-1:0]       addr_c_r;
  logic signed [33:0]  prod_c_r;
  logic                alt_c_r;
  lna_pkg::entry_t     alt_ent_c_r;

  logic signed [16:0]  diff;
  logic signed [18:0]  sum19;
  lna_pkg::entry_t     alt_ent;
  logic signed [18:0]  leaked;
  logic signed [15:0]  leaked_sat;

  always_comb begin
    diff  = $signed({in_entry.pot[15], in_entry.pot}) - $signed({cfg.target[15], cfg.target});
    sum19 = $signed({{3{in_entry.pot[15]}}, in_entry.pot})
          + $signed({{3{cfg.current[15]}}, cfg.current});
    if (in_add) begin
      alt_ent.pot  = sat16(sum19);
      alt_ent.refr = in_entry.refr;
    end else begin
      alt_ent.pot  = in_entry.pot;
      alt_ent.refr = in_entry.refr - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      vb_r <= in_valid;
      vc_r <= vb_r;
    end
    addr_b_r    <= in_addr;
    diff_b_r    <= diff;
    alt_b_r     <= in_add | (in_entry.refr != 5'd0);
    alt_ent_b_r <= alt_ent;
    addr_c_r    <= addr_b_r;
    prod_c_r    <= diff_b_r * $signed({1'b0, cfg.leak});
    alt_c_r     <= alt_b_r;
    alt_ent_c_r <= alt_ent_b_r;
  end

  // The arithmetic shift of the product floors toward minus infinity.
  always_comb begin
    leaked     = $signed({prod_c_r[33], prod_c_r[33:16]})
               + $signed({{3{cfg.target[15]}}, cfg.target});
    leaked_sat = sat16(leaked);
    out_fired  = 1'b0;
    if (alt_c_r) begin
      out_entry = alt_ent_c_r;
    end else if (leaked_sat >= cfg.threshold) begin
      out_entry.pot  = cfg.reset_pot;
      out_entry.refr = cfg.refr;
      out_fired      = vc_r;
    end else begin
      out_entry.pot  = leaked_sat;
      out_entry.refr = 5'd0;
    end
  end

  assign out_valid = vc_r;
  assign out_addr  = addr_c_r;
  assign pipe_busy = vb_r | vc_r;

endmodule

FILE: design/lna_core.sv
// ----------------------------------------------------------------------------
// lna_core
// Item sequencer: walks the neuron memory through the shared update unit,
// sweeps it after reset and on clear, and keeps the event counters.
// ----------------------------------------------------------------------------
module lna_core #(
  parameter int NEURONS = lna_pkg::NEURONS_DEF,
  parameter int AW      = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  lna_pkg::cfg_t cfg,
  input  logic          start,
  output logic          busy,
  input  logic [1:0]    in_operation,
  input  logic [9:0]    in_neuron_index,
  input  logic          in_spike_in,
  output logic          out_valid,
  output logic [10:0]   out_fired_this_tick,
  output logic [31:0]   out_total_fired,
  output logic [31:0]   out_total_events,
  output logic [31:0]   out_tick_count
);

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [10:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {22'd0, b};
    return s[32] ? 32'hffff_ffff : s[31:0];
  endfunction

  localparam logic [AW-1:0] LAST_ADDR = AW'(NEURONS - 1);

  lna_pkg::state_t state_r, state_nxt;
  lna_pkg::op_t    op_r, op_nxt;
  logic [10:0]     cnt_r, cnt_nxt;
  logic [10:0]     end_r, end_nxt;
  logic            tick_r, tick_nxt;
  logic            hit_r, hit_nxt;
  logic            clear_r, clear_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;
  logic [AW-1:0]   sweep_r, sweep_nxt;
  logic [10:0]     fired_r, fired_nxt;
  logic [31:0]     tot_fired_r, tot_fired_nxt;
  logic [31:0]     tot_events_r, tot_events_nxt;
  logic [31:0]     ticks_r, ticks_nxt;
  logic            ov_r, ov_nxt;
  logic [10:0]     of_r, of_nxt;
  logic            rv_r;

  logic [10:0]     n_active;
  logic            hit;
  logic            issue;
  logic [AW-1:0]   raddr;
  logic            we;
  logic [AW-1:0]   waddr;
  lna_pkg::entry_t wdata;
  lna_pkg::entry_t rdata;
  logic            pipe_busy;
  logic            u_valid;
  logic [AW-1:0]   u_addr;
  lna_pkg::entry_t u_entry;
  logic            u_fired;

  assign n_active = (32'(cfg.active) > 32'(NEURONS)) ? 11'(NEURONS) : cfg.active;
  assign hit      = in_spike_in & ({1'b0, in_neuron_index} < n_active);
  assign busy     = (state_r != lna_pkg::ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    cnt_nxt        = cnt_r;
    end_nxt        = end_r;
    tick_nxt       = tick_r;
    hit_nxt        = hit_r;
    clear_nxt      = clear_r;
    idx_nxt        = idx_r;
    sweep_nxt      = sweep_r;
    fired_nxt      = fired_r + {10'd0, u_fired};
    tot_fired_nxt  = tot_fired_r;
    tot_events_nxt = tot_events_r;
    ticks_nxt      = ticks_r;
    ov_nxt         = 1'b0;
    of_nxt         = of_r;
    issue          = 1'b0;
    raddr          = tick_r ? AW'(cnt_r) : idx_r;
    unique case (state_r)
      lna_pkg::ST_SWEEP: begin
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == LAST_ADDR) begin
          state_nxt = clear_r ? lna_pkg::ST_FINISH : lna_pkg::ST_IDLE;
        end
      end
      lna_pkg::ST_IDLE: begin
        if (start) begin
          op_nxt    = lna_pkg::op_t'(in_operation);
          cnt_nxt   = 11'd0;
          fired_nxt = 11'd0;
          idx_nxt   = AW'(in_neuron_index);
          hit_nxt   = hit;
          unique case (in_operation)
            lna_pkg::OP_STIM: begin
              tick_nxt  = 1'b0;
              end_nxt   = {10'd0, hit};
              state_nxt = lna_pkg::ST_ISSUE;
            end
            lna_pkg::OP_TICK: begin
              tick_nxt  = 1'b1;
              end_nxt   = n_active;
              state_nxt = lna_pkg::ST_ISSUE;
            end
            lna_pkg::OP_CLEAR: begin
              clear_nxt = 1'b1;
              sweep_nxt = '0;
              state_nxt = lna_pkg::ST_SWEEP;
            end
            default: state_nxt = lna_pkg::ST_FINISH;
          endcase
        end
      end
      lna_pkg::ST_ISSUE: begin
        if (cnt_r == end_r) begin
          state_nxt = lna_pkg::ST_DRAIN;
        end else begin
          issue   = 1'b1;
          cnt_nxt = cnt_r + 11'd1;
        end
      end
      lna_pkg::ST_DRAIN: begin
        if (!rv_r && !pipe_busy) begin
          state_nxt = lna_pkg::ST_FINISH;
        end
      end
      lna_pkg::ST_FINISH: begin
        of_nxt = 11'd0;
        unique case (op_r)
          lna_pkg::OP_STIM: begin
            if (hit_r) begin
              tot_events_nxt = sat_add32(tot_events_r, 11'd1);
            end
          end
          lna_pkg::OP_TICK: begin
            ticks_nxt      = sat_add32(ticks_r, 11'd1);
            tot_fired_nxt  = sat_add32(tot_fired_r, fired_r);
            tot_events_nxt = sat_add32(tot_events_r, fired_r);
            of_nxt         = fired_r;
          end
          lna_pkg::OP_CLEAR: begin
            ticks_nxt      = '0;
            tot_fired_nxt  = '0;
            tot_events_nxt = '0;
          end
          default: ;
        endcase
        ov_nxt    = 1'b1;
        state_nxt = lna_pkg::ST_IDLE;
      end
      default: state_nxt = lna_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= lna_pkg::ST_SWEEP;
      clear_r      <= 1'b0;
      sweep_r      <= '0;
      cnt_r        <= '0;
      end_r        <= '0;
      tick_r       <= 1'b0;
      hit_r        <= 1'b0;
      op_r         <= lna_pkg::OP_CLEAR;
      fired_r      <= '0;
      tot_fired_r  <= '0;
      tot_events_r <= '0;
      ticks_r      <= '0;
      ov_r         <= 1'b0;
      rv_r         <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clear_r      <= clear_nxt;
      sweep_r      <= sweep_nxt;
      cnt_r        <= cnt_nxt;
      end_r        <= end_nxt;
      tick_r       <= tick_nxt;
      hit_r        <= hit_nxt;
      op_r         <= op_nxt;
      fired_r      <= fired_nxt;
      tot_fired_r  <= tot_fired_nxt;
      tot_events_r <= tot_events_nxt;
      ticks_r      <= ticks_nxt;
      ov_r         <= ov_nxt;
      rv_r         <= issue;
    end
    idx_r <= idx_nxt;
    of_r  <= of_nxt;
  end

  // The sweep after reset uses the reset value of the initial potential so
  // that register writes during the sweep do not leak into it.
  always_comb begin
    we         = u_valid;
    waddr      = u_addr;
    wdata      = u_entry;
    if (state_r == lna_pkg::ST_SWEEP) begin
      we         = 1'b1;
      waddr      = sweep_r;
      wdata.pot  = clear_r ? cfg.init_pot : lna_pkg::RST_INIT_POT;
      wdata.refr = 5'd0;
    end
  end

  lna_neuron_ram #(
    .DEPTH (NEURONS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  logic [AW-1:0] rd_addr_r;
  always_ff @(posedge clk) begin
    rd_addr_r <= raddr;
  end

  lna_leak_unit #(
    .AW (AW)
  ) u_leak (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (rv_r),
    .in_add    (~tick_r),
    .in_addr   (rd_addr_r),
    .in_entry  (rdata),
    .pipe_busy (pipe_busy),
    .out_valid (u_valid),
    .out_addr  (u_addr),
    .out_entry (u_entry),
    .out_fired (u_fired)
  );

  assign out_valid           = ov_r;
  assign out_fired_this_tick = of_r;
  assign out_total_fired     = tot_fired_r;
  assign out_total_events    = tot_events_r;
  assign out_tick_count      = ticks_r;

endmodule

FILE: design/lif_neuron_array_top.sv
// ----------------------------------------------------------------------------
// lif_neuron_array_top
// Array of leaky integrate-and-fire neurons with an APB-style register port.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake            Payload
//   --------  -------------------  ----------------------------------------
//   input     start / busy         in_operation, in_neuron_index, in_spike_in
//   result    out_valid (strobe)   out_fired_this_tick, out_total_fired,
//                                  out_total_events, out_tick_count
//   config    psel/penable/pready  paddr, pwdata, pwrite, prdata
//
// A tick item visits the neuron memory's single read port once per active
// neuron, feeding the shared update pipeline; with no neuron active it
// issues no read. A stimulate item reads and rewrites one entry, or none
// when it is ignored, and a clear item rewrites one memory entry per cycle.
// After reset the block sweeps the memory and holds busy high; register
// writes are still taken during that sweep.
// Each result is shown for one cycle only; the receiver cannot stall it.
//
module lif_neuron_array_top #(
  parameter int NEURONS = lna_pkg::NEURONS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Input items.
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_operation,
  input  logic [9:0]                  in_neuron_index,
  input  logic                        in_spike_in,
  // Result items.
  output logic                        out_valid,
  output logic [10:0]                 out_fired_this_tick,
  output logic [31:0]                 out_total_fired,
  output logic [31:0]                 out_total_events,
  output logic [31:0]                 out_tick_count,
  // Configuration port.
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lna_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  // The address width is kept at one bit at least, so that a single-neuron
  // array still has a legal memory port.
  localparam int AW = (NEURONS > 1) ? $clog2(NEURONS) : 1;

  lna_pkg::cfg_t cfg;

  // Register file: all eight registers sit at word addresses.
  lna_cfg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer, neuron memory and the shared update unit.
  lna_core #(
    .NEURONS (NEURONS),
    .AW      (AW)
  ) u_core (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg),
    .start               (start),
    .busy                (busy),
    .in_operation        (in_operation),
    .in_neuron_index     (in_neuron_index),
    .in_spike_in         (in_spike_in),
    .out_valid           (out_valid),
    .out_fired_this_tick (out_fired_this_tick),
    .out_total_fired     (out_total_fired),
    .out_total_events    (out_total_events),
    .out_tick_count      (out_tick_count)
  );

endmodule

FILE: design/lna_checker.sv
// ----------------------------------------------------------------------------
// lna_checker
// Port-level checks on the neuron array, bound to the top level.
// ----------------------------------------------------------------------------
module lna_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [10:0] out_fired_this_tick,
  input logic [31:0] out_total_fired,
  input logic [31:0] out_total_events
);

  // An accepted item raises busy in the cycle after it is taken.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  // A result strobe lasts one cycle.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // Results only come out of work the block was doing.
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a preceding busy cycle");

  // Every fired spike is also an event, and the tick's spikes are in the total.
  a_counter_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_total_events >= out_total_fired) &&
                  (out_total_fired >= {21'd0, out_fired_this_tick}))
    else $error("event counters out of order");

endmodule

bind lif_neuron_array_top lna_checker u_lna_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .out_valid           (out_valid),
  .out_fired_this_tick (out_fired_this_tick),
  .out_total_fired     (out_total_fired),
  .out_total_events    (out_total_events)
);
